// ===== sv/min_distance_point_subsampler_core_defines.svh =====
// Assertion macros shared by the subsampler RTL.
// No dependencies; included by files that carry assertions.
`ifndef MIN_DISTANCE_POINT_SUBSAMPLER_CORE_DEFINES_SVH
`define MIN_DISTANCE_POINT_SUBSAMPLER_CORE_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define MDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define MDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mds_pkg.sv =====
// Shared types and constants for the minimum-distance point subsampler.
// No dependencies.
package mds_pkg;

    localparam int KEPT_MAX     = 1024;
    localparam int CNT_W        = $clog2(KEPT_MAX + 1);
    localparam int ADDR_W       = $clog2(KEPT_MAX);
    localparam int KEPT_COUNT_W = 11;
    localparam int AXES         = 3;
    localparam int COORD_W      = 16;
    localparam int POINT_W      = AXES * COORD_W;
    localparam int LIMIT_W      = 2 * COORD_W;
    localparam int SUM_W        = LIMIT_W + 2;
    localparam logic [COORD_W-1:0] MIN_DIST_RESET = 16'd256;

    typedef enum logic [1:0] {
        VERDICT_KEPT    = 2'd0,
        VERDICT_CLOSE   = 2'd1,
        VERDICT_FULL    = 2'd2,
        VERDICT_RESTART = 2'd3
    } mds_verdict_t;

    // Data handed from one distance cell to the next; low coordinate is consumed.
    typedef struct packed {
        logic               valid;
        logic [POINT_W-1:0] stored;
        logic [POINT_W-1:0] probe;
        logic [SUM_W-1:0]   sum;
    } mds_lane_t;

endpackage

// ===== sv/mds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mds_axis_cell.sv =====
// One cell of the distance chain: adds the squared difference of the low
// coordinate to the running sum and shifts the next coordinate down. Uses mds_pkg.
module mds_axis_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  mds_pkg::mds_lane_t lane_in,
    output mds_pkg::mds_lane_t lane_out
);
    import mds_pkg::*;

    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      mag;
    logic [LIMIT_W-1:0]      sq;
    logic                    valid_reg;
    logic [POINT_W-1:0]      stored_reg;
    logic [POINT_W-1:0]      probe_reg;
    logic [SUM_W-1:0]        sum_reg;

    always_comb
    begin
        diff = $signed({lane_in.probe[COORD_W-1], lane_in.probe[COORD_W-1:0]})
             - $signed({lane_in.stored[COORD_W-1], lane_in.stored[COORD_W-1:0]});
        mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
        sq   = {{COORD_W{1'b0}}, mag} * {{COORD_W{1'b0}}, mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= lane_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_reg <= {{COORD_W{1'b0}}, lane_in.stored[POINT_W-1:COORD_W]};
        probe_reg  <= {{COORD_W{1'b0}}, lane_in.probe[POINT_W-1:COORD_W]};
        sum_reg    <= lane_in.sum + SUM_W'(sq);
    end

    always_comb
    begin
        lane_out.valid  = valid_reg;
        lane_out.stored = stored_reg;
        lane_out.probe  = probe_reg;
        lane_out.sum    = sum_reg;
    end

endmodule

// ===== sv/min_distance_point_subsampler_core.sv =====
// Flow: a restart goes straight from acceptance to the result state; a point is first scanned
// against the stored points; the result loads once the output register is free.
// Throughput: one transaction at a time; the next is accepted the cycle after the result
// loads; the store is scanned one entry per cycle through the RAM read port into three
// per-axis cells.
// Reset: store empty, min_distance = 1.0 (256); RAM contents are not cleared.
module min_distance_point_subsampler_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mds_pkg::COORD_W-1:0]            cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic signed [mds_pkg::COORD_W-1:0]     pos_x,
    input  logic signed [mds_pkg::COORD_W-1:0]     pos_y,
    input  logic signed [mds_pkg::COORD_W-1:0]     pos_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             verdict,
    output logic [mds_pkg::KEPT_COUNT_W-1:0]       kept_count
);
    import mds_pkg::*;

`include "min_distance_point_subsampler_core_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [COORD_W-1:0]      min_distance_reg;
    logic [LIMIT_W-1:0]      limit_reg, limit_next;
    logic [POINT_W-1:0]      probe_reg, probe_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        addr_reg, addr_next;
    logic                    close_reg, close_next;
    logic                    rd_valid_reg;
    mds_verdict_t            verdict_pend_reg, verdict_pend_next;
    logic                    out_valid_reg, out_valid_next;
    mds_verdict_t            verdict_reg, verdict_next;
    logic [KEPT_COUNT_W-1:0] kept_count_reg, kept_count_next;

    logic                    in_fire;
    logic                    issue_active;
    logic                    in_flight;
    logic                    scan_done;
    logic                    ram_re;
    logic                    ram_we;
    logic                    store_full;
    logic [POINT_W-1:0]      ram_rdata;
    mds_lane_t               lane [AXES+1];

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign issue_active = (addr_reg != count_reg);
    assign store_full   = (count_reg == CNT_W'(KEPT_MAX));
    assign ram_re       = (state_reg == ST_SCAN) && issue_active;

    always_comb
    begin
        in_flight = 1'b0;
        for (int i = 0; i <= AXES; i++)
        begin
            in_flight = in_flight | lane[i].valid;
        end
    end

    assign scan_done = (state_reg == ST_SCAN) && !issue_active && !in_flight;
    assign ram_we    = scan_done && !close_reg && !store_full;

    mds_ram #(
        .WIDTH(POINT_W),
        .DEPTH(KEPT_MAX)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(probe_reg),
        .re   (ram_re),
        .raddr(addr_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        lane[0].valid  = rd_valid_reg;
        lane[0].stored = ram_rdata;
        lane[0].probe  = probe_reg;
        lane[0].sum    = '0;
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_cell
        mds_axis_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .lane_in (lane[g]),
            .lane_out(lane[g+1])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        limit_next        = limit_reg;
        probe_next        = probe_reg;
        count_next        = count_reg;
        addr_next         = addr_reg;
        close_next        = close_reg;
        verdict_pend_next = verdict_pend_reg;
        out_valid_next    = out_valid_reg;
        verdict_next      = verdict_reg;
        kept_count_next   = kept_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (action)
                    begin
                        count_next        = '0;
                        verdict_pend_next = VERDICT_RESTART;
                        state_next        = ST_RESULT;
                    end
                    else
                    begin
                        probe_next = {pos_z, pos_y, pos_x};
                        limit_next = {{COORD_W{1'b0}}, min_distance_reg}
                                   * {{COORD_W{1'b0}}, min_distance_reg};
                        addr_next  = '0;
                        close_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ram_re)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (lane[AXES].valid && (lane[AXES].sum < SUM_W'(limit_reg)))
                begin
                    close_next = 1'b1;
                end
                if (scan_done)
                begin
                    if (close_reg)
                    begin
                        verdict_pend_next = VERDICT_CLOSE;
                    end
                    else if (store_full)
                    begin
                        verdict_pend_next = VERDICT_FULL;
                    end
                    else
                    begin
                        verdict_pend_next = VERDICT_KEPT;
                        count_next        = count_reg + 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    verdict_next    = verdict_pend_reg;
                    kept_count_next = KEPT_COUNT_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            min_distance_reg <= MIN_DIST_RESET;
            count_reg        <= '0;
            addr_reg         <= '0;
            close_reg        <= 1'b0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            close_reg     <= close_next;
            rd_valid_reg  <= ram_re;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                min_distance_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg        <= limit_next;
        probe_reg        <= probe_next;
        verdict_pend_reg <= verdict_pend_next;
        verdict_reg      <= verdict_next;
        kept_count_reg   <= kept_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign kept_count = kept_count_reg;

    `MDS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(KEPT_MAX))
    `MDS_ASSERT_IMP(a_write_room, clk, rst_n, ram_we, count_reg < CNT_W'(KEPT_MAX))
    `MDS_ASSERT_IMP(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, addr_reg <= count_reg)
    `MDS_ASSERT_IMP(a_idle_quiet, clk, rst_n, state_reg == ST_IDLE, !in_flight)
    `MDS_ASSERT_NXT(a_busy_after, clk, rst_n, in_fire, state_reg != ST_IDLE)

endmodule

// ===== dv/min_distance_point_subsampler_core_tb.sv =====
// Self-checking testbench for min_distance_point_subsampler_core.
// Holds its own model of the point store, drives valid/ready traffic with random idling
// and checks every verdict and kept count; depends on mds_pkg and the core RTL only.
`timescale 1ns / 1ps

module min_distance_point_subsampler_core_tb;
    import mds_pkg::*;

    localparam logic ACT_POINT   = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam int  HOLD_AT      = 150;      // results seen before the long receiver stall
    localparam int  HOLD_CYCLES  = 300;
    localparam int  RAND_PHASES  = 5;
    localparam int  RAND_PER_PH  = 110;
    localparam int  TAIL_POINTS  = 8;
    localparam longint CYCLE_LIMIT = 64'd8_000_000;

    typedef struct packed {
        logic                      restart;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_item_t;

    typedef struct packed {
        mds_verdict_t              verdict;
        logic [KEPT_COUNT_W-1:0]   count;
    } outcome_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [COORD_W-1:0]        cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      action = ACT_POINT;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic signed [COORD_W-1:0] pos_z = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                verdict;
    logic [KEPT_COUNT_W-1:0]   kept_count;

    min_distance_point_subsampler_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .verdict    (verdict),
        .kept_count (kept_count)
    );

    always #1 clk = ~clk;

    point_item_t point_feed[$];
    outcome_t    verdict_due[$];

    // Model of the store
    logic signed [COORD_W-1:0] store_x [KEPT_MAX];
    logic signed [COORD_W-1:0] store_y [KEPT_MAX];
    logic signed [COORD_W-1:0] store_z [KEPT_MAX];
    int unsigned               stored_n = 0;
    logic [COORD_W-1:0]        model_min_dist = MIN_DIST_RESET;

    bit     idle_en = 1'b1;
    int     errors = 0;
    int     n_sent = 0;
    int     n_results = 0;
    int     verdict_seen [4] = '{0, 0, 0, 0};
    longint cycle_n = 0;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= 40)
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     n_results, what, want, got);
    endtask

    // Greedy spacing rule: keep when no stored point is strictly closer than min_distance and the store is not full.
    task automatic predict_verdict(input point_item_t it);
        longint   lim;
        longint   d2;
        int       dx;
        int       dy;
        int       dz;
        bit       far;
        outcome_t o;
        if (it.restart == ACT_RESTART) begin
            stored_n  = 0;
            o.verdict = VERDICT_RESTART;
        end else begin
            lim = longint'(model_min_dist) * longint'(model_min_dist);
            far = 1'b1;
            for (int i = 0; i < stored_n; i++) begin
                dx = int'(it.x) - int'(store_x[i]);
                dy = int'(it.y) - int'(store_y[i]);
                dz = int'(it.z) - int'(store_z[i]);
                d2 = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
                if (d2 < lim) begin
                    far = 1'b0;
                    break;
                end
            end
            if (!far)
                o.verdict = VERDICT_CLOSE;
            else if (stored_n >= KEPT_MAX)
                o.verdict = VERDICT_FULL;
            else begin
                store_x[stored_n] = it.x;
                store_y[stored_n] = it.y;
                store_z[stored_n] = it.z;
                stored_n++;
                o.verdict = VERDICT_KEPT;
            end
        end
        o.count = stored_n[KEPT_COUNT_W-1:0];
        verdict_due.insert(verdict_due.size(), o);
    endtask

    // Driver
    int          tx_gap = 0;
    point_item_t cur_item;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_verdict(cur_item);
                n_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (point_feed.size() != 0)
                begin
                    cur_item = point_feed.pop_front();
                    action   <= cur_item.restart;
                    pos_x    <= cur_item.x;
                    pos_y    <= cur_item.y;
                    pos_z    <= cur_item.z;
                    in_valid <= 1'b1;
                    if (idle_en && $urandom_range(0, 5) == 0)
                        tx_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver
    int       rx_gap = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    outcome_t due;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (!$isunknown(verdict))
                    verdict_seen[verdict]++;
                if (verdict_due.size() == 0)
                begin
                    report_mismatch("result with nothing pending, verdict", -1, verdict);
                end
                else
                begin
                    due = verdict_due.pop_front();
                    if (verdict !== due.verdict)
                        report_mismatch("verdict", due.verdict, verdict);
                    if (kept_count !== due.count)
                        report_mismatch("kept_count", due.count, kept_count);
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AT)
            begin
                // long stall so the input side backs up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                rx_gap = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_n++;
        if (cycle_n >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_n, verdict_due.size());
            $display("[min_distance_point_subsampler_core] ERROR");
            $finish;
        end
    end

    task automatic push_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z);
        point_item_t it;
        it.restart = ACT_POINT;
        it.x = x;
        it.y = y;
        it.z = z;
        point_feed.insert(point_feed.size(), it);
    endtask

    task automatic push_restart();
        point_item_t it;
        it.restart = ACT_RESTART;
        it.x = COORD_W'($urandom);
        it.y = COORD_W'($urandom);
        it.z = COORD_W'($urandom);
        point_feed.insert(point_feed.size(), it);
    endtask

    task automatic push_random();
        push_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Sender pause: everything issued and every result back.
    task automatic wait_drain();
        do
            @(negedge clk);
        while (point_feed.size() != 0 || in_valid || verdict_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_min_dist(input logic [COORD_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_min_dist = v;
        @(negedge clk);
    endtask

    initial
    begin
        logic [COORD_W-1:0] md;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] oz;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] fz;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset spacing of 1.0
        push_point(16'sd0, 16'sd0, 16'sd0);             // empty store always keeps
        push_point(16'sd256, 16'sd0, 16'sd0);           // exactly at the minimum
        push_point(16'sd255, 16'sd0, 16'sd0);           // too close
        push_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_point(16'sh8000, 16'sh8000, 16'sh8000);    // widest distance
        push_point(16'sh8000, 16'sh7FFF, 16'sh8000);
        push_restart();
        push_restart();                                 // restart on an empty store
        push_point(16'sh8000, 16'sh8000, 16'sh8000);
        wait_drain();

        set_min_dist(16'hFFFF);
        push_point(16'sh7FFF, 16'sh8000, 16'sh0000);
        push_point(16'sh0000, 16'sh0000, 16'sh0000);
        push_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_point(16'sh8000, 16'sh8000, 16'sh8000);
        wait_drain();

        set_min_dist(16'h0000);                         // zero spacing keeps duplicates
        push_point(16'sh0000, 16'sh0000, 16'sh0000);
        push_point(16'sh0000, 16'sh0000, 16'sh0000);
        push_point(16'sh7FFF, 16'sh8000, 16'sh0000);
        push_restart();
        push_point(16'sh1234, 16'shEDCB, 16'sh0F0F);
        wait_drain();

        // Random: clustered points against spacings of 1, cluster scale, random and 1.0, some wide noise
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       md = COORD_W'($urandom_range(64, 512));
                1:       md = 16'd1;
                2:       md = COORD_W'($urandom_range(600, 2000));
                3:       md = COORD_W'($urandom);
                default: md = MIN_DIST_RESET;
            endcase
            set_min_dist(md);
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
            cz = COORD_W'($urandom);
            push_restart();
            for (int i = 1; i < RAND_PER_PH; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    push_restart();
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    push_random();
                end
                else
                begin
                    ox = COORD_W'($urandom_range(0, 2047) - 1024);
                    oy = COORD_W'($urandom_range(0, 2047) - 1024);
                    oz = COORD_W'($urandom_range(0, 2047) - 1024);
                    push_point(cx + ox, cy + oy, cz + oz);
                end
            end
            wait_drain();
        end

        // Last part, no idling: back-to-back offers, then a repeat at the widest spacing
        idle_en = 1'b0;
        set_min_dist(16'h0000);
        push_restart();
        fx = COORD_W'($urandom);
        fy = COORD_W'($urandom);
        fz = COORD_W'($urandom);
        push_point(fx, fy, fz);
        for (int i = 1; i < TAIL_POINTS; i++)
            push_random();
        wait_drain();

        set_min_dist(16'hFFFF);
        push_point(fx, fy, fz);                         // too close to a stored point
        push_random();
        push_restart();
        push_random();
        wait_drain();

        $display("covered %0d transactions, %0d results: %0d kept, %0d too close,",
                 n_sent, n_results, verdict_seen[0], verdict_seen[1]);
        $display("%0d full, %0d restart; spacings 0, 1.0, max and random; one long stall",
                 verdict_seen[2], verdict_seen[3]);
        if (errors == 0)
            $display("[min_distance_point_subsampler_core] OK");
        else
            $display("[min_distance_point_subsampler_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mds_pkg.sv
sv/mds_ram.sv
sv/mds_axis_cell.sv
sv/min_distance_point_subsampler_core.sv
dv/min_distance_point_subsampler_core_tb.sv
